[hdl/bfsw_pkg.sv]
// Shared types and constants for the byte FIFO with shift window.
// No dependencies; the top module and the testbench import this package.
package bfsw_pkg;

  localparam int CNT_W     = 9;
  localparam int BYTE_W    = 8;
  localparam int WORD_W    = 16;
  localparam int CTR_W     = 16;
  localparam int ACT_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] CAP_RESET = 9'd256;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD  = 2'd0,
    ACT_READ = 2'd1,
    ACT_WORD = 2'd2,
    ACT_PEEK = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAPACITY = 2'd0,
    CFG_MODE     = 2'd1
  } cfg_index_e;

  typedef enum logic {
    MODE_CIRCULAR = 1'b0,
    MODE_SHIFT    = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WORD = 2'd1,
    S_FIN  = 2'd2
  } state_e;

  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [BYTE_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [WORD_W-1:0] data_out;
    logic [CNT_W-1:0]  bytes_filled;
    logic [CNT_W-1:0]  bytes_free;
    logic              counts_valid;
    logic [CTR_W-1:0]  overflow_count;
    logic [CTR_W-1:0]  underflow_count;
  } out_item_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;
  } cfg_write_t;

endpackage

[hdl/bfsw_stream_if.sv]
// Valid/ready channel carrying one payload item of type T.
// Used for the input, result and configuration channels; no dependencies.
interface bfsw_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hdl/byte_fifo_with_shift_window.sv]
// Byte FIFO of configurable capacity with a circular mode and a shift-window mode.
// Depends on bfsw_pkg, bfsw_stream_if and bfsw_byte_ram.
//
// An item (add, read byte, read 16-bit little-endian word, peek) is taken when
// the block is idle and gives one result item. Add, read and peek go from idle
// to S_FIN; a word read passes through S_WORD first, since its two bytes come
// from one single-port byte store with registered read data. Every result passes
// through a result register before the output register. A result waiting at
// the output does not hold back the next item; the block stalls only if a
// second result is ready before the first is taken. In shift mode only add is
// valid, fill counts are reported as zero with counts_valid low, and the stored
// bytes are never returned. The store needs no clearing pass after reset: a
// byte is read only after it has been written. A capacity or mode write empties
// the queue and keeps the overflow and underflow counters.
module byte_fifo_with_shift_window #(
  parameter int MAX_DEPTH = 256
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  bfsw_stream_if.sink   in_i,
  bfsw_stream_if.source out_o,
  bfsw_stream_if.sink   cfg_i
);
  import bfsw_pkg::*;

  localparam int AW      = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
  localparam int CAP_LIM = (MAX_DEPTH < 511) ? MAX_DEPTH : 511;
  localparam logic [CNT_W-1:0] CAP_MAX = CAP_LIM[CNT_W-1:0];

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cap_q, cap_d;
  mode_e            mode_q, mode_d;
  logic [CNT_W-1:0] rp_q, rp_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CTR_W-1:0] ovf_q, ovf_d;
  logic [CTR_W-1:0] unf_q, unf_d;
  logic             out_valid_q, out_valid_d;

  // staged result
  out_item_t         res_q, res_d;
  logic              use_mem_q, use_mem_d;
  logic              word_q, word_d;
  logic [CNT_W-1:0]  rp2_q, rp2_d;
  logic [BYTE_W-1:0] lo_q;
  out_item_t         out_q, out_d;

  logic              accept, cfg_acc, out_load;
  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W:0]    sum1, sum2, wsum;
  logic [CNT_W-1:0]  rp_inc, rp_inc2, waddr;
  status_e           st;
  logic              mem_en, mem_we;
  logic [AW-1:0]     mem_addr;
  logic [BYTE_W-1:0] mem_rdata;
  in_item_t          item;
  cfg_write_t        cw;

  assign item    = in_i.data;
  assign cw      = cfg_i.data;
  assign accept  = in_i.valid && in_i.ready;
  assign cfg_acc = cfg_i.valid && cfg_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cap_eff = (cap_q == '0)     ? CNT_W'(1) :
                   (cap_q > CAP_MAX) ? CAP_MAX   : cap_q;

  // wrap pointer arithmetic: operands stay below capacity, so one subtract
  assign sum1    = {1'b0, rp_q} + (CNT_W+1)'(1);
  assign sum2    = {1'b0, rp_q} + (CNT_W+1)'(2);
  assign wsum    = {1'b0, rp_q} + {1'b0, fill_q};
  assign rp_inc  = (sum1 >= {1'b0, cap_eff}) ? CNT_W'(sum1 - {1'b0, cap_eff}) : sum1[CNT_W-1:0];
  assign rp_inc2 = (sum2 >= {1'b0, cap_eff}) ? CNT_W'(sum2 - {1'b0, cap_eff}) : sum2[CNT_W-1:0];
  assign waddr   = (wsum >= {1'b0, cap_eff}) ? CNT_W'(wsum - {1'b0, cap_eff}) : wsum[CNT_W-1:0];

  // item decode, queue update and store access
  always_comb begin
    cap_d     = cap_q;
    mode_d    = mode_q;
    rp_d      = rp_q;
    fill_d    = fill_q;
    ovf_d     = ovf_q;
    unf_d     = unf_q;
    st        = ST_OK;
    use_mem_d = use_mem_q;
    word_d    = word_q;
    rp2_d     = rp2_q;
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = AW'(rp_q);

    if (cfg_acc) begin
      unique case (cw.index)
        CFG_CAPACITY: begin
          cap_d  = cw.data;
          rp_d   = '0;
          fill_d = '0;
        end
        CFG_MODE: begin
          mode_d = mode_e'(cw.data[0]);
          rp_d   = '0;
          fill_d = '0;
        end
        default: ;
      endcase
    end else if (accept) begin
      use_mem_d = 1'b0;
      word_d    = 1'b0;
      if (mode_q == MODE_SHIFT) begin
        // window contents are never read back; only the status matters
        st = (item.action == ACT_ADD) ? ST_OK : ST_INVALID;
      end else begin
        unique case (item.action)
          ACT_ADD: begin
            if (fill_q >= cap_eff) begin
              st    = ST_FULL;
              ovf_d = ovf_q + CTR_W'(1);
            end else begin
              mem_en   = 1'b1;
              mem_we   = 1'b1;
              mem_addr = AW'(waddr);
              fill_d   = fill_q + CNT_W'(1);
            end
          end
          ACT_READ: begin
            if (fill_q == '0) begin
              st    = ST_EMPTY;
              unf_d = unf_q + CTR_W'(1);
            end else begin
              mem_en    = 1'b1;
              use_mem_d = 1'b1;
              rp_d      = rp_inc;
              fill_d    = fill_q - CNT_W'(1);
            end
          end
          ACT_WORD: begin
            if (fill_q == '0) begin
              st    = ST_EMPTY;
              unf_d = unf_q + CTR_W'(1);
            end else if (fill_q == CNT_W'(1)) begin
              // consume the lone byte, then underflow on the second
              st     = ST_EMPTY;
              unf_d  = unf_q + CTR_W'(1);
              rp_d   = rp_inc;
              fill_d = '0;
            end else begin
              mem_en    = 1'b1;
              use_mem_d = 1'b1;
              word_d    = 1'b1;
              rp2_d     = rp_inc;
              rp_d      = rp_inc2;
              fill_d    = fill_q - CNT_W'(2);
            end
          end
          ACT_PEEK: begin
            if (fill_q == '0) begin
              st = ST_EMPTY;
            end else begin
              mem_en    = 1'b1;
              use_mem_d = 1'b1;
            end
          end
          default: ;
        endcase
      end
    end

    // high byte of a word read
    if (state_q == S_WORD) begin
      mem_en   = 1'b1;
      mem_we   = 1'b0;
      mem_addr = AW'(rp2_q);
    end
  end

  always_comb begin
    res_d = res_q;
    if (accept) begin
      res_d.status          = st;
      res_d.data_out        = '0;
      res_d.bytes_filled    = (mode_q == MODE_CIRCULAR) ? fill_d : '0;
      res_d.bytes_free      = (mode_q == MODE_CIRCULAR) ? (cap_eff - fill_d) : '0;
      res_d.counts_valid    = (mode_q == MODE_CIRCULAR);
      res_d.overflow_count  = ovf_d;
      res_d.underflow_count = unf_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = word_d ? S_WORD : S_FIN;
        end
      end
      S_WORD:  state_d = S_FIN;
      S_FIN: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state machine outputs; hold off an item while a register write is offered
  always_comb begin
    in_i.ready = (state_q == S_IDLE) && !cfg_i.valid;
    out_load   = (state_q == S_FIN) && (!out_valid_q || out_o.ready);
  end

  always_comb begin
    out_d = out_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_d = res_q;
      if (use_mem_q) begin
        out_d.data_out = word_q ? {mem_rdata, lo_q} : {{(WORD_W-BYTE_W){1'b0}}, mem_rdata};
      end
      out_valid_d = 1'b1;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_RESET;
      mode_q      <= MODE_CIRCULAR;
      rp_q        <= '0;
      fill_q      <= '0;
      ovf_q       <= '0;
      unf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      mode_q      <= mode_d;
      rp_q        <= rp_d;
      fill_q      <= fill_d;
      ovf_q       <= ovf_d;
      unf_q       <= unf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q     <= res_d;
    use_mem_q <= use_mem_d;
    word_q    <= word_d;
    rp2_q     <= rp2_d;
    out_q     <= out_d;
    if (state_q == S_WORD) begin
      lo_q <= mem_rdata;
    end
  end

  bfsw_byte_ram #(
    .DEPTH (MAX_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (item.data_in),
    .rdata_o (mem_rdata)
  );

endmodule

[hdl/bfsw_byte_ram.sv]
// Single-port byte store, one access per cycle, registered read data.
// No package dependencies.
module bfsw_byte_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic          we_i,
  input  logic [AW-1:0] addr_i,
  input  logic [7:0]    wdata_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

[tb/sv/tb_byte_fifo_with_shift_window.sv]
// Self-checking testbench for byte_fifo_with_shift_window: directed and random action
// streams in both modes, each result checked against an in-bench model of the queue.
// Depends on bfsw_pkg, bfsw_stream_if and the block's RTL.
`timescale 1ns / 100ps

module tb_byte_fifo_with_shift_window;
  import bfsw_pkg::*;

  localparam int STORE_DEPTH   = 256;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_PHASES = 18;
  localparam int PHASE_ITEMS   = 70;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
  localparam logic [BYTE_W-1:0]    SPACE_BYTE  = 8'h20;

  localparam int RX_STEADY  = 0;
  localparam int RX_RANDOM  = 1;
  localparam int RX_PATTERN = 2;
  localparam logic [7:0] RX_PATTERN_BITS = 8'b1011_0110;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  bfsw_stream_if #(.T(in_item_t))   item_if ();
  bfsw_stream_if #(.T(out_item_t))  result_if ();
  bfsw_stream_if #(.T(cfg_write_t)) reg_if ();

  byte_fifo_with_shift_window #(.MAX_DEPTH(STORE_DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (item_if),
    .out_o  (result_if),
    .cfg_i  (reg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Queue model state
  logic [BYTE_W-1:0] fifo_store [STORE_DEPTH];
  int unsigned       read_ptr;
  int unsigned       fill_level;
  logic [CTR_W-1:0]  refused_adds;
  logic [CTR_W-1:0]  empty_reads;
  logic [CNT_W-1:0]  cap_reg;
  mode_e             mode_reg;

  out_item_t   expected_results [$];
  out_item_t   oldest;
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned reg_writes;
  int unsigned cycle_count;

  // Receiver control: test tasks request, the receiver process counts
  int          rx_style  = RX_STEADY;
  int unsigned hold_len  = 0;
  int unsigned hold_seq  = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_tick   = 0;

  function automatic void clear_queue_model();
    read_ptr   = 0;
    fill_level = 0;
    if (mode_reg == MODE_SHIFT) begin
      foreach (fifo_store[i]) fifo_store[i] = SPACE_BYTE;
    end
  endfunction

  function automatic void write_register_model(logic [CFG_IDX_W-1:0] idx,
                                               logic [CNT_W-1:0] val);
    if (idx == CFG_CAPACITY) begin
      cap_reg = val;
      clear_queue_model();
    end else if (idx == CFG_MODE) begin
      mode_reg = mode_e'(val[0]);
      clear_queue_model();
    end
  endfunction

  function automatic bit take_oldest(int unsigned cap, output logic [BYTE_W-1:0] b);
    if (fill_level == 0) begin
      b = '0;
      empty_reads++;
      return 1'b0;
    end
    b          = fifo_store[read_ptr];
    read_ptr   = (read_ptr + 1) % cap;
    fill_level = fill_level - 1;
    return 1'b1;
  endfunction

  function automatic out_item_t predict_result(in_item_t it);
    out_item_t         r;
    int unsigned       cap;
    int unsigned       i;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    bit                ok;
    cap = (cap_reg == 0) ? 1 : ((cap_reg > STORE_DEPTH) ? STORE_DEPTH : int'(cap_reg));
    if (fill_level > cap) fill_level = cap;
    if (read_ptr >= cap) read_ptr = 0;
    r        = '0;
    r.status = ST_OK;
    if (mode_reg == MODE_SHIFT) begin
      if (action_e'(it.action) == ACT_ADD) begin
        if (fill_level < cap) begin
          fifo_store[fill_level] = it.data_in;
          fill_level++;
        end else begin
          // drop the oldest byte, append the new one last
          for (i = 0; i + 1 < cap; i++) fifo_store[i] = fifo_store[i + 1];
          fifo_store[cap - 1] = it.data_in;
        end
      end else begin
        r.status = ST_INVALID;
      end
    end else begin
      case (action_e'(it.action))
        ACT_ADD: begin
          if (fill_level >= cap) begin
            refused_adds++;
            r.status = ST_FULL;
          end else begin
            fifo_store[(read_ptr + fill_level) % cap] = it.data_in;
            fill_level++;
          end
        end
        ACT_READ: begin
          if (take_oldest(cap, lo)) r.data_out = {8'h00, lo};
          else r.status = ST_EMPTY;
        end
        ACT_WORD: begin
          // second byte is only attempted when the first was there
          ok = take_oldest(cap, lo);
          if (ok) ok = take_oldest(cap, hi);
          if (ok) r.data_out = {hi, lo};
          else r.status = ST_EMPTY;
        end
        default: begin
          if (fill_level == 0) r.status = ST_EMPTY;
          else r.data_out = {8'h00, fifo_store[read_ptr]};
        end
      endcase
      r.bytes_filled = CNT_W'(fill_level);
      r.bytes_free   = CNT_W'(cap - fill_level);
      r.counts_valid = 1'b1;
    end
    r.overflow_count  = refused_adds;
    r.underflow_count = empty_reads;
    return r;
  endfunction

  function automatic action_e pick_action(bit filling, bit shift_on);
    int unsigned r;
    int unsigned add_lim;
    int unsigned read_lim;
    int unsigned word_lim;
    r = $urandom_range(0, 99);
    if (shift_on) begin
      add_lim  = 85;
      read_lim = 90;
      word_lim = 95;
    end else begin
      add_lim  = filling ? 65 : 25;
      read_lim = add_lim + (filling ? 12 : 30);
      word_lim = read_lim + (filling ? 12 : 30);
    end
    if (r < add_lim) return ACT_ADD;
    if (r < read_lim) return ACT_READ;
    if (r < word_lim) return ACT_WORD;
    return ACT_PEEK;
  endfunction

  task automatic send_action(action_e act, logic [BYTE_W-1:0] byte_val);
    in_item_t it;
    it.action  = act;
    it.data_in = byte_val;
    @(negedge clk_i);
    item_if.valid = 1'b1;
    item_if.data  = it;
    do @(posedge clk_i); while (!item_if.ready);
    expected_results.push_back(predict_result(it));
    items_sent++;
  endtask

  task automatic idle_input(int unsigned cycles);
    @(negedge clk_i);
    item_if.valid = 1'b0;
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic wait_for_drain();
    @(negedge clk_i);
    item_if.valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CNT_W-1:0] val);
    cfg_write_t w;
    w.index = idx;
    w.data  = val;
    wait_for_drain();
    @(negedge clk_i);
    reg_if.valid = 1'b1;
    reg_if.data  = w;
    do @(posedge clk_i); while (!reg_if.ready);
    write_register_model(idx, val);
    reg_writes++;
    @(negedge clk_i);
    reg_if.valid = 1'b0;
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_if.valid && result_if.ready) begin
      if (expected_results.size() == 0) begin
        $error("result item arrived with nothing expected");
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        check_field("status", oldest.status, result_if.data.status);
        check_field("data_out", oldest.data_out, result_if.data.data_out);
        check_field("bytes_filled", oldest.bytes_filled, result_if.data.bytes_filled);
        check_field("bytes_free", oldest.bytes_free, result_if.data.bytes_free);
        check_field("counts_valid", oldest.counts_valid, result_if.data.counts_valid);
        check_field("overflow_count", oldest.overflow_count,
                    result_if.data.overflow_count);
        check_field("underflow_count", oldest.underflow_count,
                    result_if.data.underflow_count);
        results_checked++;
      end
    end
  end

  // Result receiver: long hold on request, else stall per the current style
  always @(negedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_left = hold_len;
      hold_seen = hold_seq;
    end
    if (hold_left != 0) begin
      result_if.ready = 1'b0;
      hold_left--;
    end else begin
      case (rx_style)
        RX_STEADY: result_if.ready = 1'b1;
        RX_RANDOM: result_if.ready = ($urandom_range(0, 3) != 0);
        default:   result_if.ready = RX_PATTERN_BITS[rx_tick % 8];
      endcase
    end
    rx_tick++;
  end

  always @(posedge clk_i) cycle_count++;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles, %0d results still expected",
             cycle_count, expected_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic test_empty_queue();
    rx_style = RX_STEADY;
    send_action(ACT_PEEK, 8'hFF);
    send_action(ACT_READ, 8'hFF);
    send_action(ACT_WORD, 8'h00);
    send_action(ACT_ADD, 8'h00);
    send_action(ACT_ADD, 8'hFF);
    send_action(ACT_PEEK, 8'h00);
    send_action(ACT_WORD, 8'h00);
    // word read with a single byte present
    send_action(ACT_ADD, 8'hA5);
    send_action(ACT_WORD, 8'h00);
  endtask

  task automatic test_capacity_limits();
    rx_style = RX_RANDOM;
    // zero capacity acts as one byte
    write_reg(CFG_CAPACITY, 9'h000);
    send_action(ACT_ADD, 8'h55);
    send_action(ACT_ADD, 8'h5A);
    send_action(ACT_PEEK, 8'h00);
    send_action(ACT_READ, 8'h00);
    // writes to unused indexes must not clear the queue
    send_action(ACT_ADD, 8'h3C);
    write_reg(CFG_SPARE_2, 9'h1FF);
    write_reg(CFG_SPARE_3, 9'h000);
    send_action(ACT_READ, 8'h00);
    write_reg(CFG_CAPACITY, 9'h1FF);
    send_action(ACT_ADD, 8'hC3);
    send_action(ACT_PEEK, 8'h00);
    // a capacity write empties the queue
    send_action(ACT_ADD, 8'h11);
    write_reg(CFG_CAPACITY, 9'd2);
    send_action(ACT_READ, 8'h00);
  endtask

  task automatic test_shift_window();
    rx_style = RX_PATTERN;
    write_reg(CFG_MODE, CNT_W'(MODE_SHIFT));
    send_action(ACT_ADD, 8'h41);
    send_action(ACT_ADD, 8'h42);
    send_action(ACT_ADD, 8'h43);
    send_action(ACT_READ, 8'h00);
    send_action(ACT_WORD, 8'h00);
    send_action(ACT_PEEK, 8'h00);
  endtask

  task automatic test_random_traffic();
    int unsigned      phase;
    int unsigned      n;
    int unsigned      burst_left;
    int unsigned      run_left;
    logic [CNT_W-1:0] cap_val;
    bit               filling;
    bit               gaps_on;
    bit               shift_on;
    filling = 1'b0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      case ($urandom_range(0, 7))
        0:       cap_val = 9'd1;
        1:       cap_val = 9'd2;
        2:       cap_val = 9'd0;
        3:       cap_val = 9'd256;
        4:       cap_val = CNT_W'($urandom_range(257, 511));
        5:       cap_val = CNT_W'($urandom_range(3, 8));
        default: cap_val = CNT_W'($urandom_range(9, 64));
      endcase
      shift_on = ($urandom_range(0, 2) == 0);
      if ($urandom_range(0, 1) == 0) begin
        write_reg(CFG_MODE, CNT_W'(shift_on ? MODE_SHIFT : MODE_CIRCULAR));
        write_reg(CFG_CAPACITY, cap_val);
      end else begin
        write_reg(CFG_CAPACITY, cap_val);
        write_reg(CFG_MODE, CNT_W'(shift_on ? MODE_SHIFT : MODE_CIRCULAR));
      end
      rx_style   = phase % 3;
      gaps_on    = (phase % 4 != 1);
      burst_left = 0;
      run_left   = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (gaps_on) idle_input($urandom_range(1, 6));
        end
        // alternate fill-heavy and drain-heavy runs to hit full and empty
        if (run_left == 0) begin
          run_left = $urandom_range(2, 20);
          filling  = !filling;
        end
        send_action(pick_action(filling, shift_on), BYTE_W'($urandom_range(0, 255)));
        burst_left--;
        run_left--;
      end
    end
  endtask

  task automatic test_full_store_backpressure();
    int unsigned i;
    write_reg(CFG_MODE, CNT_W'(MODE_CIRCULAR));
    write_reg(CFG_CAPACITY, 9'd256);
    rx_style = RX_STEADY;
    hold_len = HOLD_CYCLES;
    hold_seq++;
    // keep offering adds through the hold, past full
    for (i = 0; i < STORE_DEPTH + 2; i++) begin
      send_action(ACT_ADD, BYTE_W'($urandom_range(0, 255)));
    end
    for (i = 0; i < STORE_DEPTH / 2 + 1; i++) begin
      send_action(ACT_WORD, BYTE_W'($urandom_range(0, 255)));
    end
    wait_for_drain();
  endtask

  initial begin
    int unsigned drain_wait;
    item_if.valid   = 1'b0;
    item_if.data    = '0;
    reg_if.valid    = 1'b0;
    reg_if.data     = '0;
    result_if.ready = 1'b0;
    foreach (fifo_store[i]) fifo_store[i] = SPACE_BYTE;
    read_ptr        = 0;
    fill_level      = 0;
    refused_adds    = '0;
    empty_reads     = '0;
    cap_reg         = CAP_RESET;
    mode_reg        = MODE_CIRCULAR;
    mismatches      = 0;
    items_sent      = 0;
    results_checked = 0;
    reg_writes      = 0;
    cycle_count     = 0;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_queue();
    test_capacity_limits();
    test_shift_window();
    test_random_traffic();
    test_full_store_backpressure();

    @(negedge clk_i);
    item_if.valid = 1'b0;
    drain_wait = 0;
    while (expected_results.size() != 0 && drain_wait < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_wait++;
    end
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatches++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Ran %0d actions, checked %0d results, %0d register writes, %0d mismatches",
             items_sent, results_checked, reg_writes, mismatches);
    $display("Covered circular and shift modes, capacities 0 to 511, full store stall");
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
